FILE: rtl/core/zsr_pkg.sv
`default_nettype none

package zsr_pkg;

  // Element word width as carried on the ports
  localparam int WORD_BITS = 32;

  // Default frame capacity
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;

  // Configuration register width and index width
  localparam int CFG_DATA_BITS  = 7;
  localparam int CFG_INDEX_BITS = 2;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] COLUMNS_RESET = 7'd8;
  localparam logic [CFG_DATA_BITS-1:0] ROWS_RESET    = 7'd8;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COLUMNS      = 2'd0,
    REG_ROWS         = 2'd1,
    REG_INVERSE_MODE = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  // Item action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                 action;
    logic [WORD_BITS-1:0] element_word;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [WORD_BITS-1:0] element_out;
    logic                 last_of_frame;
  } out_item_t;

  // Cursor control from the top level
  typedef struct packed {
    logic step;   // take the current address and advance
    logic clear;  // return to row 0, column 0 (wins over step)
  } walk_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/zigzag_scan_reorder_core.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  in_data  (action, element_word)
// out       source     out_valid/ out_stall out_data (element_out, last_of_frame)
// cfg       sink       cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One item per cycle while not stalled: a load writes the frame RAM at its accept
// edge, a read addresses the RAM at its accept edge, where the RAM registers its word,
// and the word moves to the output register once free. One RAM port sets the rate.
// Input stalls only while a read word is waiting behind a stalled output register.
// Synchronous reset clears counters, zigzag cursor and registers; RAM is not cleared.
`default_nettype none

module zigzag_scan_reorder_core
  import zsr_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_item_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int XW    = 10;  // wide enough for 7-bit registers and 256 maximum

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] columns;
  logic [CFG_DATA_BITS-1:0] rows;
  logic                     inverse_mode;

  // Position counters and read pipeline
  logic [AW-1:0] load_position, load_position_next;
  logic [AW-1:0] read_position, read_position_next;
  logic          pend;
  logic          pend_last;

  logic [CW-1:0] nc;
  logic [RW-1:0] nr;
  logic [PW-1:0] size;
  logic          cfg_hit;
  logic          in_accept;
  logic          is_load;
  logic          pend_move;
  logic [AW-1:0] pos;
  logic          wrap;
  logic          last;
  logic [AW-1:0] walk_addr;
  logic [AW-1:0] ram_addr;
  logic [WORD_BITS-1:0] ram_rdata;
  walk_ctl_t     walk_ctl;

  // Effective frame size: zero acts as one, above maximum acts as maximum
  always_comb begin
    if (columns == '0) nc = CW'(1);
    else if (XW'(columns) > XW'(MAX_COLUMNS)) nc = CW'(MAX_COLUMNS);
    else nc = CW'(columns);
    if (rows == '0) nr = RW'(1);
    else if (XW'(rows) > XW'(MAX_ROWS)) nr = RW'(MAX_ROWS);
    else nr = RW'(rows);
  end

  always_comb begin
    size = PW'(nr * nc);
  end

  // Handshakes
  assign cfg_ready = ~pend;
  assign cfg_hit   = cfg_valid & cfg_ready & (cfg_index != REG_UNUSED);
  assign pend_move = pend & (~out_valid | ~out_stall);
  assign in_stall  = pend & out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign is_load   = (in_data.action == ACT_LOAD);

  // Position of this transaction, wrap and last detection
  always_comb begin
    pos = is_load ? load_position : read_position;
    if (PW'(pos) >= size) pos = '0;
    wrap = (PW'(pos) + PW'(1) >= size);
    last = (PW'(pos) + PW'(1) == size);
  end

  // Cursor is driven by reads in forward mode and by loads in inverse mode
  always_comb begin
    walk_ctl.step  = in_accept & (is_load == inverse_mode);
    walk_ctl.clear = cfg_hit | (in_accept & (is_load == inverse_mode) & wrap);
  end

  zsr_walk #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .ctl  (walk_ctl),
    .nr   (nr),
    .nc   (nc),
    .addr (walk_addr)
  );

  assign ram_addr = (is_load == inverse_mode) ? walk_addr : pos;

  zsr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept & is_load),
    .re    (in_accept & ~is_load),
    .addr  (ram_addr),
    .wdata (in_data.element_word),
    .rdata (ram_rdata)
  );

  // Counter next values
  always_comb begin
    load_position_next = load_position;
    read_position_next = read_position;
    if (cfg_hit) begin
      load_position_next = '0;
      read_position_next = '0;
    end else if (in_accept) begin
      if (is_load) load_position_next = wrap ? '0 : pos + AW'(1);
      else read_position_next = wrap ? '0 : pos + AW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      columns       <= COLUMNS_RESET;
      rows          <= ROWS_RESET;
      inverse_mode  <= 1'b0;
      load_position <= '0;
      read_position <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_hit) begin
        unique case (reg_index_t'(cfg_index))
          REG_COLUMNS:      columns      <= cfg_data;
          REG_ROWS:         rows         <= cfg_data;
          REG_INVERSE_MODE: inverse_mode <= cfg_data[0];
          default:          ;
        endcase
      end
      load_position <= load_position_next;
      read_position <= read_position_next;
      if (in_accept & ~is_load) pend <= 1'b1;
      else if (pend_move) pend <= 1'b0;
      if (pend_move) out_valid <= 1'b1;
      else if (~out_stall) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept & ~is_load) begin
      pend_last <= last;
    end
    if (pend_move) begin
      out_data.element_out   <= ram_rdata;
      out_data.last_of_frame <= pend_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/zsr_ram.sv
`default_nettype none

module zsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/zsr_walk.sv
`default_nettype none

module zsr_walk
  import zsr_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int RW    = $clog2(MAX_ROWS + 1),
  localparam int CW    = $clog2(MAX_COLUMNS + 1),
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire walk_ctl_t ctl,
  input  wire logic [RW-1:0] nr,   // effective rows, 1..MAX_ROWS
  input  wire logic [CW-1:0] nc,   // effective columns, 1..MAX_COLUMNS
  output logic      [AW-1:0] addr
);

  logic [RW-1:0] walk_row, walk_row_next;
  logic [CW-1:0] walk_column, walk_column_next;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [RW-1:0] r_step;
  logic [CW-1:0] c_step;
  logic [RW+CW:0] lin;

  // Clamp cursor into the frame, form the linear address
  always_comb begin
    r   = (walk_row >= nr) ? nr - RW'(1) : walk_row;
    c   = (walk_column >= nc) ? nc - CW'(1) : walk_column;
    lin = (RW+CW+1)'(r * nc) + (RW+CW+1)'(c);
    addr = AW'(lin);
  end

  // Zigzag step: up-right on even diagonals, down-left on odd ones
  always_comb begin
    r_step = r;
    c_step = c;
    if ((r[0] ^ c[0]) == 1'b0) begin
      if (r == '0) begin
        if (c == nc - CW'(1)) r_step = r + RW'(1);
        else c_step = c + CW'(1);
      end else if (c == nc - CW'(1)) begin
        r_step = r + RW'(1);
      end else begin
        r_step = r - RW'(1);
        c_step = c + CW'(1);
      end
    end else begin
      if (r == nr - RW'(1)) begin
        c_step = c + CW'(1);
      end else if (c == '0) begin
        r_step = r + RW'(1);
      end else begin
        r_step = r + RW'(1);
        c_step = c - CW'(1);
      end
    end
  end

  always_comb begin
    walk_row_next    = walk_row;
    walk_column_next = walk_column;
    if (ctl.clear) begin
      walk_row_next    = '0;
      walk_column_next = '0;
    end else if (ctl.step) begin
      walk_row_next    = r_step;
      walk_column_next = c_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_row    <= '0;
      walk_column <= '0;
    end else begin
      walk_row    <= walk_row_next;
      walk_column <= walk_column_next;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import zsr_pkg::*;
();

  localparam int FRAME_WORDS = MAX_ROWS_DEF * MAX_COLUMNS_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 4;

  // Recognizable words for the directed frames
  localparam logic [31:0] W0 = 32'h0000_0000;
  localparam logic [31:0] W1 = 32'hFFFF_FFFF;
  localparam logic [31:0] W2 = 32'hA5A5_5A5A;
  localparam logic [31:0] W3 = 32'h5A5A_A5A5;
  localparam logic [31:0] W4 = 32'h0123_4567;
  localparam logic [31:0] W5 = 32'hFEDC_BA98;
  localparam logic [31:0] WS = 32'h8000_0001;

  localparam logic [6:0] EXTREME_DIMS [4] = '{7'd0, 7'd1, 7'd64, 7'd127};

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_item_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  zigzag_scan_reorder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Directed rows: a register write, or an item with an optional hand-typed result
  typedef struct {
    bit          is_cfg;
    reg_index_t  idx;
    logic [6:0]  cval;
    logic        act;
    logic [31:0] word;
    bit          typed;
    logic [31:0] exp_word;
    logic        exp_last;
  } dir_row_t;

  // 3x2 zigzag visits raster addresses 0,1,3,4,2,5
  dir_row_t dir_rows [32] = '{
    '{1'b1, REG_COLUMNS,      7'd3,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b1, REG_ROWS,         7'd2,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W1, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W2, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W3, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W4, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W5, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W1, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W3, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W4, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W2, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W5, 1'b1},
    // inverse: zigzag in, raster out; unknown index mid-frame is ignored
    '{1'b1, REG_INVERSE_MODE, 7'd1,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W5, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W4, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W3, 1'b0, W0, 1'b0},
    '{1'b1, REG_UNUSED,       7'h7F,  ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W2, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W1, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W5, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W4, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W1, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W3, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, W2, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W1, 1'b1, W0, 1'b1},
    // zero sizes act as a 1x1 frame
    '{1'b1, REG_COLUMNS,      7'd0,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b1, REG_ROWS,         7'd0,   ACT_LOAD, W0, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_LOAD, WS, 1'b0, W0, 1'b0},
    '{1'b0, REG_COLUMNS,      7'd0,   ACT_READ, W0, 1'b1, WS, 1'b1}
  };

  // Shadow of the block: registers, counters, zigzag cursor and frame store
  logic [6:0]  zz_cols;
  logic [6:0]  zz_rows;
  logic        zz_inv;
  int unsigned load_pos;
  int unsigned read_pos;
  int unsigned walk_r;
  int unsigned walk_c;
  logic [31:0] shadow_frame   [FRAME_WORDS];
  bit          shadow_written [FRAME_WORDS];

  out_item_t   expected_words [$];

  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_writes;
  int unsigned mismatches;
  int unsigned max_frame;
  bit          jitter_on;

  function automatic int unsigned clamp_dim(input logic [6:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned frame_size();
    return clamp_dim(zz_rows, MAX_ROWS_DEF) * clamp_dim(zz_cols, MAX_COLUMNS_DEF);
  endfunction

  function automatic void restart_walk();
    load_pos = 0;
    read_pos = 0;
    walk_r   = 0;
    walk_c   = 0;
  endfunction

  // Raster address under the zigzag cursor, cursor clamped into the frame
  function automatic int unsigned zz_addr();
    int unsigned nc, nr, r, c;
    nc = clamp_dim(zz_cols, MAX_COLUMNS_DEF);
    nr = clamp_dim(zz_rows, MAX_ROWS_DEF);
    r = (walk_r >= nr) ? nr - 1 : walk_r;
    c = (walk_c >= nc) ? nc - 1 : walk_c;
    return r * nc + c;
  endfunction

  // Take the cursor address, then snake one step along the anti-diagonals
  function automatic int unsigned zz_take();
    int unsigned nc, nr, r, c, addr;
    nc   = clamp_dim(zz_cols, MAX_COLUMNS_DEF);
    nr   = clamp_dim(zz_rows, MAX_ROWS_DEF);
    addr = zz_addr();
    r    = addr / nc;
    c    = addr % nc;
    if (((r + c) & 1) == 0) begin
      if (r == 0) begin
        if (c == nc - 1) r++;
        else c++;
      end else if (c == nc - 1) begin
        r++;
      end else begin
        r--;
        c++;
      end
    end else begin
      if (r == nr - 1) c++;
      else if (c == 0) r++;
      else begin
        r++;
        c--;
      end
    end
    walk_r = r;
    walk_c = c;
    return addr;
  endfunction

  // Advance the shadow by one transaction; returns 1 when a word comes out
  function automatic bit reorder_step(input in_item_t it, output out_item_t res);
    int unsigned size, pos, addr;
    size = frame_size();
    res  = '0;
    if (it.action == ACT_LOAD) begin
      pos  = (load_pos >= size) ? 0 : load_pos;
      addr = zz_inv ? zz_take() : pos;
      shadow_frame[addr]   = it.element_word;
      shadow_written[addr] = 1'b1;
      load_pos = pos + 1;
      if (load_pos >= size) begin
        load_pos = 0;
        if (zz_inv) begin
          walk_r = 0;
          walk_c = 0;
        end
      end
      return 1'b0;
    end
    pos  = (read_pos >= size) ? 0 : read_pos;
    addr = zz_inv ? pos : zz_take();
    res.element_out   = shadow_frame[addr];
    res.last_of_frame = (pos == size - 1);
    read_pos = pos + 1;
    if (read_pos >= size) begin
      read_pos = 0;
      if (!zz_inv) begin
        walk_r = 0;
        walk_c = 0;
      end
    end
    return 1'b1;
  endfunction

  // A read is only issued when the entry it lands on has been loaded
  function automatic bit read_is_safe();
    int unsigned size, addr;
    size = frame_size();
    if (zz_inv) addr = (read_pos >= size) ? 0 : read_pos;
    else addr = zz_addr();
    return shadow_written[addr];
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Drive one item and wait for its transaction
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    gap = 0;
    jitter_on = (n_items < 400 || n_items >= 600);
    while (jitter_on && $urandom_range(0, 99) < 26) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_items++;
    if (reorder_step(it, res)) expected_words = {expected_words, (typed ? typed_res : res)};
  endtask

  task automatic issue(input logic act, input logic [31:0] word);
    in_item_t it;
    it.action       = (act == ACT_READ && !read_is_safe()) ? ACT_LOAD : act;
    it.element_word = word;
    send_item(it, 1'b0, '0);
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(input reg_index_t idx, input logic [6:0] val);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      REG_COLUMNS:      zz_cols = val;
      REG_ROWS:         zz_rows = val;
      REG_INVERSE_MODE: zz_inv  = val[0];
      default: ;
    endcase
    if (idx != REG_UNUSED) restart_walk();
    if (frame_size() > max_frame) max_frame = frame_size();
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= jitter_on && ($urandom_range(0, 99) < 26);
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_results++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word %h last %b", out_data.element_out,
                   out_data.last_of_frame);
      end else begin
        want = expected_words.pop_front();
        if (out_data.element_out !== want.element_out ||
            out_data.last_of_frame !== want.last_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d word exp %h got %h, last exp %b got %b",
                     n_results, want.element_out, out_data.element_out,
                     want.last_of_frame, out_data.last_of_frame);
        end
      end
    end
  end

  // Main sequence
  initial begin
    in_item_t    it;
    out_item_t   typed_res;
    logic [6:0]  new_cols, new_rows, big, other;
    int unsigned nframes, size, n, guard;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= '0;
    jitter_on  = 1'b1;
    n_items    = 0;
    n_results  = 0;
    n_writes   = 0;
    mismatches = 0;
    zz_cols    = COLUMNS_RESET;
    zz_rows    = ROWS_RESET;
    zz_inv     = 1'b0;
    max_frame  = frame_size();
    restart_walk();
    foreach (shadow_written[k]) shadow_written[k] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frames
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        write_reg(dir_rows[k].idx, dir_rows[k].cval);
      end else begin
        it.action                 = dir_rows[k].act;
        it.element_word           = dir_rows[k].word;
        typed_res.element_out     = dir_rows[k].exp_word;
        typed_res.last_of_frame   = dir_rows[k].exp_last;
        send_item(it, dir_rows[k].typed, typed_res);
      end
    end

    // Random phases: mostly whole frames loaded then read back, some mixed traffic
    while (n_items < RANDOM_ITEMS + 26) begin
      if ($urandom_range(0, 99) < 15) begin
        big   = EXTREME_DIMS[$urandom_range(0, 3)];
        other = 7'($urandom_range(1, 2));
        if ($urandom_range(0, 1)) {new_cols, new_rows} = {big, other};
        else {new_cols, new_rows} = {other, big};
      end else begin
        new_cols = 7'($urandom_range(1, 6));
        new_rows = 7'($urandom_range(1, 6));
      end
      if ($urandom_range(0, 99) < 70) write_reg(REG_COLUMNS, new_cols);
      if ($urandom_range(0, 99) < 70) write_reg(REG_ROWS, new_rows);
      if ($urandom_range(0, 99) < 50)
        write_reg(REG_INVERSE_MODE, 7'($urandom_range(0, 127)));
      if ($urandom_range(0, 99) < 5) write_reg(REG_UNUSED, 7'($urandom_range(0, 127)));

      size = frame_size();
      if ($urandom_range(0, 99) < 75) begin
        nframes = (size > 32) ? 1 : $urandom_range(1, 2);
        repeat (nframes) begin
          repeat (size) issue(ACT_LOAD, rand_word());
          repeat (size) issue(ACT_READ, rand_word());
        end
      end else begin
        n = $urandom_range(10, 40);
        repeat (n) issue(1'($urandom_range(0, 1)), rand_word());
      end
    end

    // Drain
    in_valid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("ERROR: %0d expected words never arrived", expected_words.size());
      mismatches += expected_words.size();
    end

    $display("Reorder run: %0d items, %0d words checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("Frames up to %0d words in both scan directions; %0d mismatches",
             max_frame, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("ERROR: timeout with %0d words outstanding", expected_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/zsr_pkg.sv
rtl/core/zsr_ram.sv
rtl/core/zsr_walk.sv
rtl/core/zigzag_scan_reorder_core.sv
sim/tb_top.sv
